FILE: hdl/lps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lexicographic permutation stepper package
// Shared widths, slot types and the identity ordering.
// ----------------------------------------------------------------------------
package lps_pkg;

  // Largest element count the block supports.
  localparam int MAX_ELEMENTS = 8;
  // Bits per slot and number of slots that the packed ordering carries.
  localparam int SLOT_BITS    = 3;
  localparam int OUT_SLOTS    = 8;
  localparam int ORDER_BITS   = SLOT_BITS * OUT_SLOTS;
  localparam int COUNT_BITS   = 4;

  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef slot_t [OUT_SLOTS-1:0] order_arr_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // Effective element count saturates at the smaller of the two limits.
  localparam count_t COUNT_MAX =
    count_t'((MAX_ELEMENTS < OUT_SLOTS) ? MAX_ELEMENTS : OUT_SLOTS);

  // Result of one step, passed from the successor logic to the top level.
  typedef struct packed {
    logic [ORDER_BITS-1:0] order;
    logic                  is_last;
  } step_result_t;

  // Identity ordering: slot k holds k.
  function automatic order_arr_t identity();
    order_arr_t id;
    for (int k = 0; k < OUT_SLOTS; k++) begin
      id[k] = slot_t'(k);
    end
    return id;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/lps_successor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lexicographic successor logic
// Packs the current ordering and computes its lexicographic successor with
// a parallel pivot search, successor search, swap and suffix reversal.
// ----------------------------------------------------------------------------
module lps_successor (
  input  wire lps_pkg::order_arr_t   cur,
  input  wire lps_pkg::count_t       n,
  output lps_pkg::order_arr_t        nxt,
  output lps_pkg::step_result_t      res
);

  logic [lps_pkg::OUT_SLOTS-2:0] asc;
  logic                          found;
  lps_pkg::slot_t                pivot;
  lps_pkg::slot_t                pv;
  lps_pkg::slot_t                succ;
  logic [lps_pkg::COUNT_BITS:0]  src_w;
  lps_pkg::slot_t                src;

  // Pivot search: rightmost ascent inside the active slots.
  always_comb begin
    pivot = '0;
    for (int k = 0; k < lps_pkg::OUT_SLOTS - 1; k++) begin
      asc[k] = (lps_pkg::COUNT_BITS'(k + 1) < n) && (cur[k] < cur[k+1]);
      if (asc[k]) begin
        pivot = lps_pkg::slot_t'(k);
      end
    end
    found = |asc;
    pv    = cur[pivot];
  end

  // Successor search: rightmost active slot holding a value above the pivot.
  always_comb begin
    succ = '0;
    for (int k = 0; k < lps_pkg::OUT_SLOTS; k++) begin
      if ((lps_pkg::COUNT_BITS'(k) < n) && (cur[k] > pv)) begin
        succ = lps_pkg::slot_t'(k);
      end
    end
  end

  // Swap and suffix reversal; a descending ordering wraps to the identity.
  always_comb begin
    src_w = '0;
    src   = '0;
    for (int k = 0; k < lps_pkg::OUT_SLOTS; k++) begin
      if (!found) begin
        nxt[k] = lps_pkg::slot_t'(k);
      end else if ((lps_pkg::COUNT_BITS'(k) < n) && (lps_pkg::slot_t'(k) > pivot)) begin
        // Slot k takes the mirrored suffix slot n + pivot - k.
        src_w  = (lps_pkg::COUNT_BITS+1)'(n) + (lps_pkg::COUNT_BITS+1)'(pivot)
               - (lps_pkg::COUNT_BITS+1)'(k);
        src    = src_w[lps_pkg::SLOT_BITS-1:0];
        nxt[k] = (src == succ) ? pv : cur[src];
      end else if (lps_pkg::slot_t'(k) == pivot) begin
        nxt[k] = cur[succ];
      end else begin
        nxt[k] = cur[k];
      end
    end
  end

  // Emitted beat: active slots packed, unused slots zero.
  always_comb begin
    res.order = '0;
    for (int k = 0; k < lps_pkg::OUT_SLOTS; k++) begin
      if (lps_pkg::COUNT_BITS'(k) < n) begin
        res.order[k*lps_pkg::SLOT_BITS +: lps_pkg::SLOT_BITS] = cur[k];
      end
    end
    res.is_last = !found;
  end

endmodule
`default_nettype wire

FILE: hdl/lexicographic_permutation_stepper.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Lexicographic permutation stepper
// Emits the orderings of 0..n_used-1 in lexicographic order, one per beat.
// ----------------------------------------------------------------------------
// The block accepts one request beat per clock cycle and returns one result
// beat for each, in the cycle after acceptance, from an output register. The
// rate is set by the combinational successor logic that reads the stored
// ordering register and writes the next ordering back in the same cycle as
// the result is registered. A request is stalled only while a result waits
// in the output register and the sink stalls it. Writing n_used (clamped to
// 1..8) reloads the identity ordering; write it only while the block is idle.
// ----------------------------------------------------------------------------
module lexicographic_permutation_stepper (
  input  wire                              clk,
  input  wire                              rst_n,
  // Request channel
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire                              in_restart,
  // Result channel
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [lps_pkg::ORDER_BITS-1:0]   out_order,
  output logic                             out_is_last,
  // Configuration channel
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [lps_pkg::COUNT_BITS-1:0]   cfg_data
);

  lps_pkg::order_arr_t   order_r;
  lps_pkg::order_arr_t   order_nxt;
  lps_pkg::order_arr_t   cur;
  lps_pkg::count_t       n_used_r;
  lps_pkg::count_t       n_eff;
  lps_pkg::step_result_t res;
  logic                  out_valid_r;
  logic [lps_pkg::ORDER_BITS-1:0] out_order_r;
  logic                  out_is_last_r;
  logic                  in_fire;
  logic                  cfg_fire;

  // Handshakes: the output register frees up when its beat is taken.
  assign in_stall  = out_valid_r && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Clamp the element count into the supported range.
  always_comb begin
    if (n_used_r == '0) begin
      n_eff = lps_pkg::count_t'(1);
    end else if (n_used_r > lps_pkg::COUNT_MAX) begin
      n_eff = lps_pkg::COUNT_MAX;
    end else begin
      n_eff = n_used_r;
    end
  end

  // A restart beat works from the identity instead of the stored ordering.
  assign cur = in_restart ? lps_pkg::identity() : order_r;

  lps_successor u_successor (
    .cur (cur),
    .n   (n_eff),
    .nxt (order_nxt),
    .res (res)
  );

  // Ordering state and count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_used_r <= lps_pkg::count_t'(3);
      order_r  <= lps_pkg::identity();
    end else if (cfg_fire) begin
      n_used_r <= cfg_data;
      order_r  <= lps_pkg::identity();
    end else if (in_fire) begin
      order_r  <= order_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_order_r   <= res.order;
      out_is_last_r <= res.is_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_order   = out_order_r;
  assign out_is_last = out_is_last_r;

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexicographic permutation stepper testbench
// A directed table covers reset state, wrap, restart and the count extremes.
// Random phases then follow at many element counts. An in-bench successor
// model checks every result beat while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic CONTINUE     = 1'b0;
  localparam logic RESTART      = 1'b1;
  localparam int   RANDOM_ITEMS = 420;
  localparam int   CYCLE_LIMIT  = 200000;
  localparam int   LONG_HOLD    = 300;
  localparam int   DRAIN_CYCLES = 4;

  // One row of the directed table. A row may rewrite the count first, and it
  // may carry a typed-in result in place of the model's.
  typedef struct packed {
    bit                    write_cnt;
    lps_pkg::count_t       cnt;
    logic                  restart;
    bit                    typed;
    lps_pkg::step_result_t want;
  } dir_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic                           in_restart;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [lps_pkg::ORDER_BITS-1:0] out_order;
  logic                           out_is_last;
  logic                           cfg_valid;
  logic                           cfg_ready;
  lps_pkg::count_t                cfg_data;

  // Successor model state and the orderings still owed by the block.
  lps_pkg::order_arr_t   perm_now;
  lps_pkg::count_t       count_now;
  lps_pkg::step_result_t owed_orders[$];

  int errors        = 0;
  int cycles        = 0;
  int burst_left    = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int stall_mode    = 0;
  int mode_left     = 0;

  dir_row_t dir_rows [22];

  lexicographic_permutation_stepper dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_order  (out_order),
    .out_is_last(out_is_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Put the model ordering back to slot k = k.
  function automatic void load_identity_model();
    for (int k = 0; k < lps_pkg::OUT_SLOTS; k++) begin
      perm_now[k] = lps_pkg::slot_t'(k);
    end
  endfunction

  // Emit the current ordering, then step the model to its successor.
  function automatic lps_pkg::step_result_t advance_ordering(input logic restart);
    lps_pkg::step_result_t res;
    int                    n;
    int                    pivot;
    bit                    found;
    int                    j;
    int                    lo;
    int                    hi;
    lps_pkg::slot_t        t;
    n = int'(count_now);
    if (n < 1) n = 1;
    if (n > int'(lps_pkg::COUNT_MAX)) n = int'(lps_pkg::COUNT_MAX);
    if (restart) load_identity_model();
    res.order = '0;
    for (int k = 0; k < n; k++) begin
      res.order[lps_pkg::SLOT_BITS*k +: lps_pkg::SLOT_BITS] = perm_now[k];
    end
    // The pivot is the rightmost ascent.
    found = 1'b0;
    pivot = 0;
    for (int k = 0; k + 1 < n; k++) begin
      if (perm_now[k] < perm_now[k+1]) begin
        pivot = k;
        found = 1'b1;
      end
    end
    res.is_last = !found;
    if (!found) begin
      load_identity_model();
    end else begin
      // Swap the pivot with the rightmost larger slot, then reverse the tail.
      j = n - 1;
      while (perm_now[j] <= perm_now[pivot]) j--;
      t               = perm_now[pivot];
      perm_now[pivot] = perm_now[j];
      perm_now[j]     = t;
      lo = pivot + 1;
      hi = n - 1;
      while (lo < hi) begin
        t            = perm_now[lo];
        perm_now[lo] = perm_now[hi];
        perm_now[hi] = t;
        lo++;
        hi--;
      end
    end
    return res;
  endfunction

  // Offer one request beat, with a random gap at the start of each burst.
  task automatic send_request(input logic restart, input bit typed,
                              input lps_pkg::step_result_t typed_res);
    int                    gap;
    lps_pkg::step_result_t model_res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    model_res = advance_ordering(restart);
    owed_orders.insert(owed_orders.size(), typed ? typed_res : model_res);
  endtask

  // Stop sending and wait until every owed result beat has come back.
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (owed_orders.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the element count; the block reloads the identity ordering.
  task automatic write_count(input lps_pkg::count_t value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    count_now = value;
    load_identity_model();
  endtask

  // Result side: random stall modes, plus a long hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      mode_left <= 0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= LONG_HOLD;
      out_stall   <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  // Compare each result beat with the oldest owed ordering.
  always @(posedge clk) begin
    lps_pkg::step_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_orders.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, order %h is_last %b",
                 $time, out_order, out_is_last);
      end else begin
        want = owed_orders.pop_front();
        if (out_order !== want.order) begin
          errors++;
          $display("%0t: order expected %h actual %h", $time, want.order, out_order);
        end
        if (out_is_last !== want.is_last) begin
          errors++;
          $display("%0t: is_last expected %b actual %b",
                   $time, want.is_last, out_is_last);
        end
      end
    end
  end

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    int              sent;
    int              phase;
    int              phase_len;
    int              sel;
    lps_pkg::count_t cnt;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_restart = CONTINUE;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    count_now  = 4'd3;
    load_identity_model();

    // Reset state is three elements; 2,1,0 is the last ordering, then wrap.
    // Counts 0 and 1 give a single ordering; 8 and 15 both give eight slots.
    dir_rows = '{
      '{1'b0, 4'd0,  CONTINUE, 1'b1, '{24'h000088, 1'b0}},
      '{1'b0, 4'd0,  CONTINUE, 1'b0, '{24'h000000, 1'b0}},
      '{1'b0, 4'd0,  CONTINUE, 1'b0, '{24'h000000, 1'b0}},
      '{1'b0, 4'd0,  CONTINUE, 1'b0, '{24'h000000, 1'b0}},
      '{1'b0, 4'd0,  CONTINUE, 1'b0, '{24'h000000, 1'b0}},
      '{1'b0, 4'd0,  CONTINUE, 1'b1, '{24'h00000A, 1'b1}},
      '{1'b0, 4'd0,  CONTINUE, 1'b1, '{24'h000088, 1'b0}},
      '{1'b0, 4'd0,  CONTINUE, 1'b0, '{24'h000000, 1'b0}},
      '{1'b0, 4'd0,  RESTART,  1'b1, '{24'h000088, 1'b0}},
      '{1'b1, 4'd1,  CONTINUE, 1'b1, '{24'h000000, 1'b1}},
      '{1'b0, 4'd0,  RESTART,  1'b1, '{24'h000000, 1'b1}},
      '{1'b1, 4'd0,  CONTINUE, 1'b1, '{24'h000000, 1'b1}},
      '{1'b1, 4'd8,  CONTINUE, 1'b1, '{24'hFAC688, 1'b0}},
      '{1'b0, 4'd0,  CONTINUE, 1'b0, '{24'h000000, 1'b0}},
      '{1'b0, 4'd0,  RESTART,  1'b1, '{24'hFAC688, 1'b0}},
      '{1'b1, 4'd15, CONTINUE, 1'b1, '{24'hFAC688, 1'b0}},
      '{1'b0, 4'd0,  CONTINUE, 1'b0, '{24'h000000, 1'b0}},
      '{1'b1, 4'd2,  CONTINUE, 1'b1, '{24'h000008, 1'b0}},
      '{1'b0, 4'd0,  CONTINUE, 1'b1, '{24'h000001, 1'b1}},
      '{1'b0, 4'd0,  CONTINUE, 1'b1, '{24'h000008, 1'b0}},
      '{1'b1, 4'd4,  RESTART,  1'b0, '{24'h000000, 1'b0}},
      '{1'b0, 4'd0,  CONTINUE, 1'b0, '{24'h000000, 1'b0}}
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].write_cnt) begin
        drain();
        write_count(dir_rows[i].cnt);
      end
      send_request(dir_rows[i].restart, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases: mostly small counts so that the orderings wrap often.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 15);
      if (sel < 10) begin
        cnt = lps_pkg::count_t'($urandom_range(2, 4));
      end else if (sel < 12) begin
        cnt = lps_pkg::count_t'($urandom_range(0, 1));
      end else if (sel < 14) begin
        cnt = lps_pkg::count_t'($urandom_range(5, 7));
      end else begin
        cnt = lps_pkg::count_t'($urandom_range(8, 15));
      end
      phase_len = (cnt >= 4'd8) ? $urandom_range(5, 15) : $urandom_range(20, 60);
      drain();
      write_count(cnt);
      for (int i = 0; i < phase_len; i++) begin
        // Twice in the run the result side holds off while requests keep coming.
        if ((phase == 2 || phase == 7) && i == 3) begin
          hold_requests <= hold_requests + 1;
        end
        send_request(($urandom_range(0, 19) == 0) ? RESTART : CONTINUE, 1'b0, '0);
        sent++;
      end
      phase++;
    end

    drain();
    if (errors == 0 && owed_orders.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/lps_pkg.sv
hdl/lps_successor.sv
hdl/lexicographic_permutation_stepper.sv
tb/testbench.sv
